// ===== sv/tvcb_pkg.sv =====
`timescale 1ns / 1ps

package tvcb_pkg;

  localparam int CONF_BITS  = 16;
  localparam int DEPTH_BITS = 16;
  localparam int COLOR_BITS = 8;
  localparam int NUM_CH     = 3;

  // product of one confidence and one byte, sum over two views
  localparam int PROD_W = CONF_BITS + COLOR_BITS;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SUM_W  = CONF_BITS + 1;

  // quotient bits, two per divide stage
  localparam int Q_W        = COLOR_BITS;
  localparam int DIV_STAGES = Q_W / 2;
  localparam int NUM_STAGES = 2 + DIV_STAGES;

  localparam int VIEW_BITS   = CONF_BITS + DEPTH_BITS + NUM_CH * COLOR_BITS;
  localparam int IN_TDATA_W  = ((2 * VIEW_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = NUM_CH * COLOR_BITS + DEPTH_BITS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TUSER_W = 1;

  typedef struct packed {
    logic [NUM_CH-1:0][PROD_W-1:0] pa;
    logic [NUM_CH-1:0][PROD_W-1:0] pb;
    logic [CONF_BITS-1:0]          ca;
    logic [CONF_BITS-1:0]          cb;
    logic [DEPTH_BITS-1:0]         depth;
  } mul_t;

  typedef struct packed {
    logic [NUM_CH-1:0][ACC_W-1:0]  acc;
    logic [SUM_W-1:0]              sum;
    logic [DEPTH_BITS-1:0]         depth;
  } sum_t;

  typedef struct packed {
    logic [NUM_CH-1:0][ACC_W-1:0]  rem;
    logic [NUM_CH-1:0][Q_W-1:0]    q;
    logic [SUM_W-1:0]              sum;
    logic [DEPTH_BITS-1:0]         depth;
  } div_t;

endpackage

// ===== sv/two_view_confidence_blend_unit.sv =====
`timescale 1ns / 1ps

// channel      dir  tdata (low bit up)                              tuser
// s_*          in   a_conf a_depth a_blue a_green a_red             a_is_main b_is_main
//                   b_conf b_depth b_blue b_green b_red
// m_*          out  out_blue out_green out_red out_depth            written
// cfg_*        in   cfg_wdata = gate_by_label on cfg_we             -
//
// one beat per cycle while the output is not stalled, six register stages from input beat to output beat:
// multiply, sum, then four divide stages of two quotient bits each
// rst clears all stage valid bits and gate_by_label
// each stage holds while the next one is full and stalled, so empty stages
// keep filling under an output stall; nothing is lost or repeated

module two_view_confidence_blend_unit
  import tvcb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // a_conf, a_depth, a_blue, a_green, a_red, b_conf, b_depth, b_blue, b_green, b_red
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // a_is_main, b_is_main
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_blue, out_green, out_red, out_depth
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // written
  output logic [OUT_TUSER_W-1:0] m_tuser
);

  logic                        gate_by_label;
  logic [NUM_STAGES-1:0]       vld;
  logic [NUM_STAGES-1:0]       rdy;

  logic [CONF_BITS-1:0]        a_conf, b_conf;
  logic [DEPTH_BITS-1:0]       a_depth, b_depth;
  logic [NUM_CH-1:0][COLOR_BITS-1:0] a_col, b_col;
  logic                        use_a, use_b;

  mul_t mul, mul_next;
  sum_t sm, sm_next;
  div_t dv [DIV_STAGES];
  div_t dv_in [DIV_STAGES];
  div_t dv_next [DIV_STAGES];

  logic                        written;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_by_label <= 1'b0;
    end else if (cfg_we) begin
      gate_by_label <= cfg_wdata;
    end
  end

  // stage handshake
  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = rdy[0];

  // unpack
  always_comb begin
    a_conf  = s_tdata[CONF_BITS-1:0];
    a_depth = s_tdata[CONF_BITS +: DEPTH_BITS];
    b_conf  = s_tdata[VIEW_BITS +: CONF_BITS];
    b_depth = s_tdata[VIEW_BITS + CONF_BITS +: DEPTH_BITS];
    for (int c = 0; c < NUM_CH; c++) begin
      a_col[c] = s_tdata[CONF_BITS + DEPTH_BITS + c * COLOR_BITS +: COLOR_BITS];
      b_col[c] = s_tdata[VIEW_BITS + CONF_BITS + DEPTH_BITS + c * COLOR_BITS +: COLOR_BITS];
    end
    use_a = !gate_by_label || s_tuser[0];
    use_b = !gate_by_label || s_tuser[1];
  end

  // stage 1: gate, multiply, min depth
  always_comb begin
    mul_next.ca = use_a ? a_conf : '0;
    mul_next.cb = use_b ? b_conf : '0;
    for (int c = 0; c < NUM_CH; c++) begin
      mul_next.pa[c] = PROD_W'(mul_next.ca) * PROD_W'(a_col[c]);
      mul_next.pb[c] = PROD_W'(mul_next.cb) * PROD_W'(b_col[c]);
    end
    if (use_a && use_b) begin
      mul_next.depth = (b_depth < a_depth) ? b_depth : a_depth;
    end else if (use_a) begin
      mul_next.depth = a_depth;
    end else if (use_b) begin
      mul_next.depth = b_depth;
    end else begin
      mul_next.depth = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mul <= mul_next;
    end
  end

  // stage 2: sums
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sm_next.acc[c] = ACC_W'(mul.pa[c]) + ACC_W'(mul.pb[c]);
    end
    sm_next.sum   = SUM_W'(mul.ca) + SUM_W'(mul.cb);
    sm_next.depth = mul.depth;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sm <= sm_next;
    end
  end

  // divide stages, restoring, quotient fits in one byte
  always_comb begin
    dv_in[0].rem   = sm.acc;
    dv_in[0].q     = '0;
    dv_in[0].sum   = sm.sum;
    dv_in[0].depth = sm.depth;
    for (int k = 1; k < DIV_STAGES; k++) begin
      dv_in[k] = dv[k-1];
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int HI = Q_W - 1 - 2 * k;

    always_comb begin
      logic [ACC_W-1:0] shd;
      dv_next[k] = dv_in[k];
      for (int j = 0; j < 2; j++) begin
        shd = ACC_W'(dv_in[k].sum) << (HI - j);
        for (int c = 0; c < NUM_CH; c++) begin
          if (dv_next[k].rem[c] >= shd) begin
            dv_next[k].rem[c]        = dv_next[k].rem[c] - shd;
            dv_next[k].q[c][HI - j]  = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[2 + k]) begin
        dv[k] <= dv_next[k];
      end
    end
  end

  // output
  assign written  = (dv[DIV_STAGES-1].sum != '0);
  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tuser  = OUT_TUSER_W'(written);

  always_comb begin
    m_tdata = '0;
    if (written) begin
      for (int c = 0; c < NUM_CH; c++) begin
        m_tdata[c * COLOR_BITS +: COLOR_BITS] = dv[DIV_STAGES-1].q[c];
      end
      m_tdata[NUM_CH * COLOR_BITS +: DEPTH_BITS] = dv[DIV_STAGES-1].depth;
    end
  end

endmodule

// ===== sv/tvcb_checker.sv =====
`timescale 1ns / 1ps

module tvcb_checker
  import tvcb_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser
);

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  // with the output stage empty every stage can take a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage empty");

  // unwritten pixels carry zero payload
  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("unwritten beat with nonzero payload");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

endmodule

bind two_view_confidence_blend_unit tvcb_checker u_tvcb_checker (.*);

// ===== dv/two_view_confidence_blend_unit_checker.sv =====
`timescale 1ns / 1ps

module two_view_confidence_blend_unit_checker
  import tvcb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // a_conf, a_depth, a_blue, a_green, a_red, b_conf, b_depth, b_blue, b_green, b_red
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // a_is_main, b_is_main
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // out_blue, out_green, out_red, out_depth
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  // written
  input  logic [OUT_TUSER_W-1:0] m_tuser,
  output int                     mismatches,
  output int                     pending,
  output int                     blended
);

  typedef struct packed {
    logic       written;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [15:0] depth;
  } pixel_res_t;

  pixel_res_t blend_q[$];
  logic       gate_main;

  function automatic pixel_res_t blend_pixel(logic gate, logic [IN_TDATA_W-1:0] d,
                                             logic [IN_TUSER_W-1:0] u);
    longint unsigned conf_sum;
    longint unsigned acc[3];
    longint unsigned conf;
    longint unsigned mean;
    logic [15:0]     depth;
    logic [15:0]     depth_min;
    bit              any_view;
    int              base;
    pixel_res_t      r;
    conf_sum  = 0;
    depth_min = '0;
    any_view  = 0;
    for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
    for (int v = 0; v < 2; v++) begin
      base  = v * 56;
      conf  = d[base +: 16];
      depth = d[base + 16 +: 16];
      if (!(gate && !u[v])) begin
        conf_sum += conf;
        if (!any_view || depth < depth_min) depth_min = depth;
        any_view = 1;
        for (int ch = 0; ch < 3; ch++) acc[ch] += conf * d[base + 32 + 8 * ch +: 8];
      end
    end
    r = '0;
    if (conf_sum != 0) begin
      r.written = 1'b1;
      mean = acc[0] / conf_sum;
      r.blue = (mean > 255) ? 8'hff : mean[7:0];
      mean = acc[1] / conf_sum;
      r.green = (mean > 255) ? 8'hff : mean[7:0];
      mean = acc[2] / conf_sum;
      r.red = (mean > 255) ? 8'hff : mean[7:0];
      r.depth = depth_min;
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t pixel %s mismatch: expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pixel_res_t want;
    pixel_res_t got;
    if (rst) begin
      blend_q.delete();
      gate_main  = 1'b0;
      mismatches = 0;
      pending    = 0;
      blended    = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[39:24]};
        if (blend_q.size() == 0) begin
          $display("%0t unexpected output beat: expected none actual %h", $time, got);
          mismatches++;
        end else begin
          want = blend_q.pop_front();
          check_field("written", want.written, got.written);
          check_field("blue", want.blue, got.blue);
          check_field("green", want.green, got.green);
          check_field("red", want.red, got.red);
          check_field("depth", want.depth, got.depth);
          if (got.written) blended++;
        end
      end
      if (s_tvalid && s_tready) blend_q.push_back(blend_pixel(gate_main, s_tdata, s_tuser));
      if (cfg_we) gate_main = cfg_wdata;
      pending = blend_q.size();
    end
  end

endmodule

// ===== dv/two_view_confidence_blend_unit_test.sv =====
`timescale 1ns / 1ps

module two_view_confidence_blend_unit_test
  import tvcb_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 180;

  typedef struct {
    logic        is_main;
    logic [15:0] conf;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } view_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic                   cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  int mismatches;
  int pending;
  int blended;
  int sent;
  int idle_cycles;
  bit calm;
  bit burst;
  bit hold_req;

  two_view_confidence_blend_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  two_view_confidence_blend_unit_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .pending    (pending),
    .blended    (blended)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic view_t view(logic m, logic [15:0] c, logic [15:0] d,
                                 logic [7:0] b, logic [7:0] g, logic [7:0] r);
    view_t v;
    v.is_main = m;
    v.conf    = c;
    v.depth   = d;
    v.blue    = b;
    v.green   = g;
    v.red     = r;
    return v;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic view_t rand_view();
    return view(1'($urandom_range(0, 1)), rand_word(), rand_word(),
                rand_byte(), rand_byte(), rand_byte());
  endfunction

  // called right after a rising edge, returns at the edge that takes the beat
  task automatic send_pixel(view_t a, view_t b);
    bit took;
    if (!calm && !burst && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b.red, b.green, b.blue, b.depth, b.conf,
                 a.red, a.green, a.blue, a.depth, a.conf};
    s_tuser  <= {b.is_main, a.is_main};
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_gate(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver side
  initial begin
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("two_view_confidence_blend_unit_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    sent        = 0;
    calm        = 1'b0;
    burst       = 1'b0;
    hold_req    = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gating off
    write_gate(1'b0);
    send_pixel(view(0, 16'h0000, 16'd100, 8'd10, 8'd20, 8'd30),
               view(1, 16'h0000, 16'd50, 8'd40, 8'd50, 8'd60));
    send_pixel(view(1, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff),
               view(1, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff));
    send_pixel(view(0, 16'hffff, 16'h0000, 8'h00, 8'h00, 8'h00),
               view(0, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff));
    send_pixel(view(1, 16'h0000, 16'd5, 8'hff, 8'hff, 8'hff),
               view(1, 16'd1000, 16'd900, 8'd10, 8'd20, 8'd30));
    send_pixel(view(1, 16'h0001, 16'd1234, 8'hff, 8'h00, 8'h80),
               view(1, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_pixel(view(0, 16'h0001, 16'h0000, 8'd1, 8'd2, 8'd3),
               view(0, 16'hffff, 16'h0001, 8'd254, 8'd253, 8'd252));
    send_pixel(view(1, 16'h8000, 16'hffff, 8'haa, 8'h55, 8'hff),
               view(1, 16'h8000, 16'hfffe, 8'h55, 8'haa, 8'h00));
    send_pixel(view(1, 16'h0001, 16'h0001, 8'h00, 8'hff, 8'h00),
               view(0, 16'hffff, 16'h0002, 8'hff, 8'h00, 8'hff));
    drain();

    // gating on
    write_gate(1'b1);
    send_pixel(view(0, 16'hffff, 16'd10, 8'd200, 8'd200, 8'd200),
               view(1, 16'h0001, 16'd20, 8'd7, 8'd8, 8'd9));
    send_pixel(view(0, 16'hffff, 16'd10, 8'hff, 8'hff, 8'hff),
               view(0, 16'hffff, 16'd20, 8'hff, 8'hff, 8'hff));
    send_pixel(view(1, 16'h0000, 16'd3, 8'hff, 8'hff, 8'hff),
               view(0, 16'hffff, 16'd1, 8'hff, 8'hff, 8'hff));
    send_pixel(view(1, 16'hffff, 16'hffff, 8'hff, 8'h00, 8'h7f),
               view(1, 16'hffff, 16'h0000, 8'h00, 8'hff, 8'h80));
    send_pixel(view(1, 16'h1234, 16'd500, 8'd11, 8'd22, 8'd33),
               view(0, 16'h4321, 16'd1, 8'd44, 8'd55, 8'd66));
    send_pixel(view(0, 16'hffff, 16'h0000, 8'h00, 8'h00, 8'h00),
               view(1, 16'h0001, 16'hffff, 8'hff, 8'hff, 8'hff));
    drain();

    for (int p = 0; p < 5; p++) begin
      calm = (p == 4);
      write_gate(p[0]);
      if (p == 2) begin
        // long output stall while the input keeps offering
        hold_req = 1'b1;
        burst    = 1'b1;
        repeat (40) send_pixel(rand_view(), rand_view());
        burst = 1'b0;
      end
      repeat (PHASE_ITEMS) send_pixel(rand_view(), rand_view());
      drain();
    end

    repeat (20) @(posedge clk);
    $display("%0d pixels sent with label gating off and on, %0d blended, %0d left unwritten",
             sent, blended, sent - blended);
    if (mismatches == 0 && pending == 0) begin
      $display("two_view_confidence_blend_unit_test OK");
    end else begin
      $display("two_view_confidence_blend_unit_test NOT OK");
    end
    $finish;
  end

endmodule
